// ----- src/cursor_sequence_store_macros.svh -----
// Assertion macros for the cursor sequence store checker.
`ifndef CURSOR_SEQUENCE_STORE_MACROS_SVH
`define CURSOR_SEQUENCE_STORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cursor_sequence_store check failed");

// Next-cycle implication, disabled during reset.
`define CSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cursor_sequence_store check failed");

`endif

// ----- src/csq_pkg.sv -----
// Package: widths, operation and status codes, cell command type.
package csq_pkg;

  localparam int ENTRY_W      = 64;
  localparam int FUNC_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_START   = 3'd0,
    FN_ADVANCE = 3'd1,
    FN_INSERT  = 3'd2,
    FN_ATTACH  = 3'd3,
    FN_REMOVE  = 3'd4,
    FN_QUERY   = 3'd5
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_NOITEM = 2'd2
  } status_t;

  // Broadcast to every cell: open a gap at pos, or close the gap at pos.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

endpackage

// ----- src/csq_if.sv -----
// Request and response channel interfaces.
interface csq_req_if;
  logic                         valid;
  logic                         ready;
  logic [csq_pkg::FUNC_W-1:0]   func;
  logic [csq_pkg::ENTRY_W-1:0]  value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface csq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [csq_pkg::STATUS_W-1:0]  status;
  logic                          has_item;
  logic [csq_pkg::ENTRY_W-1:0]   current_value;
  logic [csq_pkg::COUNT_W-1:0]   count;

  modport source (output valid, output status, output has_item, output current_value,
                  output count, input ready);
  modport sink   (input valid, input status, input has_item, input current_value,
                  input count, output ready);
endinterface

// ----- src/cursor_sequence_store.sv -----
// Top level: ordered store of 64-bit entries with a cursor, built as a chain of cells.
//
// Requests arrive on req (func, value) and each one yields exactly one response on
// rsp (status, has_item, current_value, count), in order. Both channels use a
// valid/ready handshake; an item moves on a rising edge with both high.
// Every entry sits in its own cell. Insert and attach open a gap by having all
// cells above the position take their lower neighbor's entry in the same cycle;
// remove closes it by having cells take their upper neighbor's entry. The cell
// under the cursor drives the read bus, which is OR-collected into the response.
// A request accepted in the idle state updates the cells, count and cursor and
// moves the store to the busy state, where the read-out loads the response
// register and raises rsp.valid. No new request is taken in the busy state, so
// the store is through with the cell update before it takes the next request.
// The response register frees the request side: a new request is taken as soon
// as the pending response is being taken or the register is empty. While the
// receiver stalls, the response holds and req.ready stays low.
// Reset (synchronous, rst high) empties the store and parks the cursor at zero;
// cell contents are not cleared and are never shown before they are written.
module cursor_sequence_store #(
  parameter int CAPACITY = csq_pkg::CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  csq_req_if.sink    req,
  csq_rsp_if.source  rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] cursor;
  logic [CW-1:0] cursor_next;
  logic [CW-1:0] pos;
  csq_pkg::status_t status;
  csq_pkg::status_t status_next;
  csq_pkg::cell_cmd_t cmd;

  logic [csq_pkg::ENTRY_W-1:0] ent [CAPACITY];
  logic [csq_pkg::ENTRY_W-1:0] rd  [CAPACITY];
  logic [csq_pkg::ENTRY_W-1:0] sel;

  logic acc;
  logic full;
  logic has_cur;
  logic can_adv;

  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign acc       = req.valid && req.ready;
  assign full      = count == CAP_VAL;
  assign has_cur   = cursor < count;
  assign can_adv   = ({1'b0, cursor} + 1'b1) < {1'b0, count};

  always_comb begin
    cmd         = '0;
    pos         = cursor;
    cursor_next = cursor;
    count_next  = count;
    status_next = csq_pkg::STAT_DONE;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          state_next = ST_BUSY;
          case (req.func)
            csq_pkg::FN_START: begin
              if (count != '0) begin
                cursor_next = '0;
              end
            end
            csq_pkg::FN_ADVANCE: begin
              if (can_adv) begin
                cursor_next = cursor + 1'b1;
              end
            end
            csq_pkg::FN_INSERT: begin
              if (full) begin
                status_next = csq_pkg::STAT_FULL;
              end else begin
                cmd.shift_up = 1'b1;
                count_next   = count + 1'b1;
              end
            end
            csq_pkg::FN_ATTACH: begin
              if (full) begin
                status_next = csq_pkg::STAT_FULL;
              end else begin
                pos          = has_cur ? cursor + 1'b1 : count;
                cmd.shift_up = 1'b1;
                count_next   = count + 1'b1;
                cursor_next  = pos;
              end
            end
            csq_pkg::FN_REMOVE: begin
              if (has_cur) begin
                cmd.shift_down = 1'b1;
                count_next     = count - 1'b1;
              end else begin
                status_next = csq_pkg::STAT_NOITEM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_BUSY: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  generate
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [csq_pkg::ENTRY_W-1:0] left;
      logic [csq_pkg::ENTRY_W-1:0] right;
      if (g == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = ent[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = ent[g+1];
      end
      csq_cell #(
        .CW    (CW),
        .INDEX (g)
      ) u_cell (
        .clk    (clk),
        .cmd    (cmd),
        .pos    (pos),
        .cursor (cursor),
        .value  (req.value),
        .left   (left),
        .right  (right),
        .entry  (ent[g]),
        .rd     (rd[g])
      );
    end
  endgenerate

  // Collect the one cell that drives the read bus.
  always_comb begin
    sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel = sel | rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      cursor <= '0;
      status <= csq_pkg::STAT_DONE;
    end else begin
      state  <= state_next;
      count  <= count_next;
      cursor <= cursor_next;
      if (acc) begin
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_BUSY) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_BUSY) begin
      rsp.status        <= status;
      rsp.has_item      <= has_cur;
      rsp.current_value <= has_cur ? sel : '0;
      rsp.count         <= csq_pkg::COUNT_W'(count);
    end
  end

endmodule

// ----- src/csq_cell.sv -----
// One storage cell of the entry chain: holds one entry, trades with its neighbors.
module csq_cell #(
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  csq_pkg::cell_cmd_t            cmd,
  input  logic [CW-1:0]                 pos,
  input  logic [CW-1:0]                 cursor,
  input  logic [csq_pkg::ENTRY_W-1:0]   value,
  input  logic [csq_pkg::ENTRY_W-1:0]   left,
  input  logic [csq_pkg::ENTRY_W-1:0]   right,
  output logic [csq_pkg::ENTRY_W-1:0]   entry,
  output logic [csq_pkg::ENTRY_W-1:0]   rd
);

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

  logic above;
  logic at_pos;

  assign above  = MY_IDX > pos;
  assign at_pos = MY_IDX == pos;

  always_ff @(posedge clk) begin
    if (cmd.shift_up) begin
      if (above) begin
        entry <= left;
      end else if (at_pos) begin
        entry <= value;
      end
    end else if (cmd.shift_down) begin
      if (above || at_pos) begin
        entry <= right;
      end
    end
  end

  // Drive the entry onto the read bus only when the cursor sits here.
  assign rd = (cursor == MY_IDX) ? entry : '0;

endmodule

// ----- src/csq_checker.sv -----
// Port-level checker for the cursor sequence store, bound to the top level.
`include "cursor_sequence_store_macros.svh"

module csq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic                          rsp_has_item,
  input logic [csq_pkg::ENTRY_W-1:0]   rsp_current_value,
  input logic [csq_pkg::COUNT_W-1:0]   rsp_count
);

  // One request in flight at a time.
  `CSQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
  // Every accepted request shows a valid response once the busy state has loaded the response register.
  `CSQ_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, ##1 rsp_valid)
  // No current item means a zero value.
  `CSQ_ASSERT_NOW(a_empty_value, rsp_valid && !rsp_has_item, rsp_current_value == '0)
  // A stalled response stays valid and holds its current value and count.
  `CSQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_current_value) && $stable(rsp_count))

endmodule

bind cursor_sequence_store csq_checker u_csq_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_has_item      (rsp.has_item),
  .rsp_current_value (rsp.current_value),
  .rsp_count         (rsp.count)
);

// ----- tb/sv/cursor_sequence_store_check.sv -----
// Response checker for the cursor sequence store: tracks the store and compares every response.
module cursor_sequence_store_check
  import csq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  csq_req_if   req,
  csq_rsp_if   rsp,
  output int   fail_count,
  output int   pending,
  output int   checked,
  output int   full_rejects,
  output int   empty_removes
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t              status;
    logic                 has_item;
    logic [ENTRY_W-1:0]   current_value;
    logic [COUNT_W-1:0]   count;
  } store_view_t;

  logic [ENTRY_W-1:0] cells [CAPACITY];
  int unsigned        fill;
  int unsigned        cur;
  store_view_t        expected_views [$];
  store_view_t        want;

  // Open a gap at pos and put v there; caller guarantees room.
  function automatic void open_gap(int unsigned pos, logic [ENTRY_W-1:0] v);
    for (int unsigned i = fill; i > pos; i--) cells[i] = cells[i-1];
    cells[pos] = v;
    fill++;
  endfunction

  function automatic store_view_t apply_op(logic [FUNC_W-1:0] fn, logic [ENTRY_W-1:0] v);
    store_view_t view;
    int unsigned pos;
    view.status = STAT_DONE;
    case (fn)
      FN_START:   if (fill != 0) cur = 0;
      FN_ADVANCE: if (cur + 1 < fill) cur++;
      FN_INSERT: begin
        if (fill >= CAPACITY) view.status = STAT_FULL;
        else open_gap(cur, v);
      end
      FN_ATTACH: begin
        if (fill >= CAPACITY) begin
          view.status = STAT_FULL;
        end else begin
          pos = (cur < fill) ? cur + 1 : fill;
          open_gap(pos, v);
          cur = pos;
        end
      end
      FN_REMOVE: begin
        if (cur < fill) begin
          for (int unsigned i = cur; i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
        end else begin
          view.status = STAT_NOITEM;
        end
      end
      default: ;
    endcase
    view.has_item      = (cur < fill);
    view.current_value = view.has_item ? cells[cur] : '0;
    view.count         = COUNT_W'(fill);
    return view;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      cur = 0;
      expected_views.delete();
      fail_count = 0;
      checked = 0;
      full_rejects = 0;
      empty_removes = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          $error("unexpected response: status %0d count %0d", rsp.status, rsp.count);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          checked++;
          if (want.status == STAT_FULL) full_rejects++;
          if (want.status == STAT_NOITEM) empty_removes++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.has_item !== want.has_item) begin
            $error("has_item: expected %0d, got %0d", want.has_item, rsp.has_item);
            fail_count++;
          end
          if (rsp.current_value !== want.current_value) begin
            $error("current_value: expected %h, got %h", want.current_value,
                   rsp.current_value);
            fail_count++;
          end
          if (rsp.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp.count);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) expected_views.push_back(apply_op(req.func, req.value));
    end
    pending = expected_views.size();
  end

endmodule

// ----- tb/sv/cursor_sequence_store_test.sv -----
// Top of the cursor sequence store testbench: clock, reset, stimulus and verdict.
module cursor_sequence_store_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csq_pkg::*;

  localparam int PERIOD = 10;
  localparam int LIMIT  = 400000;
  localparam int MAX_GAP = 13;
  // Codes with no operation behind them; the store must treat them as a query.
  localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm;
  int   items_sent;
  int   cycle_count;
  int   fail_count, pending, checked, full_rejects, empty_removes;

  csq_req_if req ();
  csq_rsp_if rsp ();

  cursor_sequence_store DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  cursor_sequence_store_check #(.CAPACITY(CAPACITY_DEF)) watch (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .full_rejects  (full_rejects),
    .empty_removes (empty_removes)
  );

  always #(PERIOD/2) clk = ~clk;

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [ENTRY_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, ENTRY_W-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // grow and shrink are percentages of inserts/attaches and of removes.
  function automatic logic [FUNC_W-1:0] pick_func(int grow, int shrink);
    int r;
    r = $urandom_range(0, 99);
    if (r < grow) return $urandom_range(0, 1) ? FN_INSERT : FN_ATTACH;
    if (r < grow + shrink) return FN_REMOVE;
    case ($urandom_range(0, 9))
      0, 1:          return FN_START;
      2, 3, 4, 5, 6: return FN_ADVANCE;
      7:             return FN_QUERY;
      8:             return FN_SPARE_LO;
      default:       return FN_SPARE_HI;
    endcase
  endfunction

  // Enter and leave at a rising edge; valid stays high when the next item follows at once.
  task automatic send_item(logic [FUNC_W-1:0] fn, logic [ENTRY_W-1:0] v);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.func  <= fn;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold off the sender until every response is back.
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic run_phase(int n, int grow, int shrink);
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      send_item(pick_func(grow, shrink), pick_value());
    end
  endtask

  // Response side: stall a random number of cycles before each response.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.func  = FN_QUERY;
    req.value = '0;
    calm = 1'b0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty store: nothing moves, remove is refused, spare codes act as query.
    send_item(FN_QUERY, '0);
    send_item(FN_START, '0);
    send_item(FN_ADVANCE, '0);
    send_item(FN_REMOVE, '0);
    send_item(FN_SPARE_LO, '1);
    send_item(FN_SPARE_HI, '1);
    // Insert into empty, attach after, insert before the cursor.
    send_item(FN_INSERT, '1);
    send_item(FN_ATTACH, '0);
    send_item(FN_INSERT, 64'h8000_0000_0000_0001);
    send_item(FN_ADVANCE, '0);
    send_item(FN_ADVANCE, '0);
    // Remove the last entry: cursor parks past the end.
    send_item(FN_REMOVE, '0);
    send_item(FN_ADVANCE, '0);
    send_item(FN_ATTACH, 64'h5555_5555_5555_5555);
    send_item(FN_REMOVE, '0);
    send_item(FN_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(FN_START, '0);
    send_item(FN_REMOVE, '0);
    send_item(FN_REMOVE, '0);
    send_item(FN_REMOVE, '0);
    send_item(FN_REMOVE, '0);
    send_item(FN_START, '0);
    wait_drained();

    run_phase(200, 40, 30);
    wait_drained();
    // Grow well past capacity so full rejections show up often.
    run_phase(250, 75, 10);
    wait_drained();
    // Drain back toward empty.
    run_phase(200, 10, 60);
    wait_drained();
    run_phase(150, 45, 35);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sequence store: %0d requests sent, %0d responses checked.", items_sent, checked);
    $display("Refused on a full store: %0d; removes with no current entry: %0d.",
             full_rejects, empty_removes);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/csq_pkg.sv
src/csq_if.sv
src/csq_cell.sv
src/cursor_sequence_store.sv
src/csq_checker.sv
tb/sv/cursor_sequence_store_check.sv
tb/sv/cursor_sequence_store_test.sv
